FILE: rtl/aes128_pkg.sv
// AES-128 core package: payload structs, S-box functions, MixColumns helpers.
// Depends on nothing; imported by every module in rtl/.
`default_nettype none
package aes128_pkg;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_upper;
        logic [63:0] block_lower;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
    } t_out_item;

    localparam logic [0:0] REG_KEY_UPPER = 1'b0;
    localparam logic [0:0] REG_KEY_LOWER = 1'b1;
    localparam logic       DIR_ENC       = 1'b0;
    localparam logic [7:0] RCON_FIRST    = 8'h01;
    localparam logic [7:0] GF_POLY       = 8'h1b;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    // 32-bit word helpers; byte 0 of a column sits in bits 31:24
    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix via the 04/05 pre-multiply, then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/aes128_keymem.sv
// Round-key memory and key expansion sequencer: 44 words, one written per cycle.
// Depends on aes128_pkg.
`default_nettype none
module aes128_keymem (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_key,
    input  wire logic [5:0]   i_rd_addr,
    output logic      [31:0]  o_rd_data,
    output logic              o_busy
);
    import aes128_pkg::*;

    localparam int unsigned DEPTH = 44;

    logic [31:0] r_mem [DEPTH];
    logic        r_busy, n_busy;
    logic [5:0]  r_idx, n_idx;
    logic [7:0]  r_rc, n_rc;
    // last four words, w[i-4]..w[i-1]; rotates through the key for words 0..3
    logic [127:0] r_win, n_win;
    logic [31:0]  w_new, t;

    always_comb begin
        t = r_win[31:0];
        if (r_idx[1:0] == 2'd0)
            t = subst_word({t[23:0], t[31:24]}) ^ {r_rc, 24'h0};
        // key words pass straight through
        if (r_idx < 6'd4) t = '0;
        w_new = r_win[127:96] ^ t;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_rc   = r_rc;
        n_win  = r_win;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = 6'd0;
            n_rc   = RCON_FIRST;
            n_win  = i_key;
        end else if (r_busy) begin
            n_win = {r_win[95:0], w_new};
            n_idx = r_idx + 6'd1;
            if (r_idx >= 6'd4 && r_idx[1:0] == 2'd0) n_rc = xtime(r_rc);
            if (r_idx == 6'(DEPTH - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_rc  <= n_rc;
        r_win <= n_win;
    end

    // memory: one word per cycle while busy
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_idx] <= w_new;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_busy = r_busy;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < 6'(DEPTH))) else $error("key index out of range");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_idx == 6'(DEPTH - 1) && !i_start) |=> !r_busy) else $error("expansion overrun");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_idx == 6'd0)) else $error("expansion start");
endmodule
`default_nettype wire

FILE: rtl/aes128_block_cipher_core.sv
// AES-128 top level: handshake, round sequencer, one shared round unit.
// Depends on aes128_pkg and aes128_keymem.
// Per request, 11 round steps each read four key words and then apply the round; the
// result then loads the output register. One item in flight; a held result does not
// block input, but a finished block stalls input until the output register drains.
// Reset: key registers clear and the zero key is expanded (no input taken).
`default_nettype none
module aes128_block_cipher_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire aes128_pkg::t_in_item   i_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output aes128_pkg::t_out_item       o_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [0:0]             i_cfg_index,
    input  wire logic [63:0]            i_cfg_data
);
    import aes128_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [127:0] r_key;
    logic         r_rekey;
    logic         r_boot;
    logic         kbusy;
    logic [31:0]  kdata;
    logic [5:0]   r_addr, n_addr;
    logic [1:0]   r_st, n_st;
    logic [3:0]   r_round, n_round;
    logic [1:0]   r_col, n_col;
    logic         r_dec;
    logic [127:0] r_s, n_s;
    logic [127:0] r_rk, n_rk;
    logic [127:0] rk_cur;
    logic         r_rdv;
    logic [1:0]   r_rdcol;
    logic         r_ov;
    logic [127:0] r_res;
    logic         accept;
    logic         out_load;
    logic [127:0] rnd_out;

    // key registers; any write triggers a re-expansion
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_rekey <= 1'b0;
            r_boot  <= 1'b1;
        end else begin
            r_boot  <= 1'b0;
            r_rekey <= i_cfg_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY_UPPER: r_key[127:64] <= i_cfg_data;
                    REG_KEY_LOWER: r_key[63:0]   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    aes128_keymem u_keymem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_rekey || r_boot),
        .i_key     (r_key),
        .i_rd_addr (r_addr),
        .o_rd_data (kdata),
        .o_busy    (kbusy)
    );

    assign o_stall  = (r_st != ST_IDLE) || kbusy || r_rekey || r_boot;
    assign accept   = i_valid && !o_stall;
    // output register takes the finished block once it is empty or draining
    assign out_load = (r_st == ST_OUT) && (!r_ov || !i_stall);

    // round key with the word arriving this cycle merged in
    always_comb begin
        rk_cur = r_rk;
        if (r_rdv) rk_cur[127 - 32*r_rdcol -: 32] = kdata;
    end

    // round unit: encrypt SB,SR,MC,ARK; decrypt ISR,ISB,ARK,IMC; no MC or IMC in round 10
    always_comb begin
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [127:0] sx;
        logic last;
        last = r_dec ? (r_round == 4'd10) : (r_round == 4'd10);
        for (int i = 0; i < 16; i++) b[i] = r_s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (r_dec) t[4*c + r] = inv_sbox(b[4*((c - r + 4) % 4) + r]);
                else       t[4*c + r] = sbox(b[4*((c + r) % 4) + r]);
            end
        for (int i = 0; i < 16; i++) sx[127 - 8*i -: 8] = t[i];
        if (r_dec) begin
            sx = sx ^ rk_cur;
            if (!last)
                for (int c = 0; c < 4; c++)
                    sx[127 - 32*c -: 32] = inv_mix_col(sx[127 - 32*c -: 32]);
            rnd_out = sx;
        end else begin
            if (!last)
                for (int c = 0; c < 4; c++)
                    sx[127 - 32*c -: 32] = mix_col(sx[127 - 32*c -: 32]);
            rnd_out = sx ^ rk_cur;
        end
    end

    // sequencer: fetch four key words per round, then apply
    always_comb begin
        n_st = r_st; n_addr = r_addr; n_round = r_round; n_col = r_col;
        n_s = r_s;
        n_rk = rk_cur;
        unique case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    n_st = ST_LOAD; n_col = 2'd0; n_round = 4'd0;
                    n_addr = i_data.req_type ? 6'd40 : 6'd0;
                    n_s = {i_data.block_upper, i_data.block_lower};
                end
            end
            ST_LOAD: begin
                n_addr = r_addr + 6'd1;
                n_col  = r_col + 2'd1;
                if (r_col == 2'd3) begin
                    n_st = ST_RUN;
                    n_addr = r_addr;
                end
            end
            ST_RUN: begin
                // wait for last word, then apply the round
                if (r_rdv && r_rdcol == 2'd3) begin
                    if (r_round == 4'd0) n_s = r_s ^ rk_cur;
                    else                n_s = rnd_out;
                    if (r_round == 4'd10) begin
                        n_st = ST_OUT;
                    end else begin
                        n_round = r_round + 4'd1;
                        n_st = ST_LOAD; n_col = 2'd0;
                        n_addr = r_dec ? 6'(6'd36 - {r_round, 2'b00}) : 6'({r_round + 4'd1, 2'b00});
                    end
                end
            end
            ST_OUT: begin
                if (out_load) n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_rdv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_rdv <= (r_st == ST_LOAD);
            if (out_load) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
        r_rdcol <= r_col;
        r_addr  <= n_addr;
        r_round <= n_round;
        r_col   <= n_col;
        r_s     <= n_s;
        r_rk    <= n_rk;
        if (accept) r_dec <= i_data.req_type;
        if (out_load) r_res <= r_s;
    end

    assign o_valid = r_ov;
    assign o_data  = '{result_upper: r_res[127:64], result_lower: r_res[63:0]};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_res))) else $error("stalled result changed");
    a_no_accept_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kbusy |-> !accept) else $error("item accepted during key expansion");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> (r_round <= 4'd10)) else $error("round overrun");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for aes128_block_cipher_core: directed vectors, then random traffic.
// Depends on aes128_pkg and the core RTL; carries its own AES-128 predictor.
`timescale 1ns / 1ps
module testbench;
    import aes128_pkg::*;

    localparam int N_RANDOM   = 1930;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 100;

    typedef enum logic { OP_ENC = 1'b0, OP_DEC = 1'b1 } t_op;

    // directed row: key update, request, optional typed-in answer
    typedef struct {
        bit        load_key;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        t_op       op;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        bit        has_known;
        t_out_item known;
    } t_vec;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [0:0] cfg_index;
    logic [63:0] cfg_data;

    aes128_block_cipher_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predictor state: the key and its schedule
    logic [127:0] cur_key;
    logic [31:0]  sched [44];
    logic [7:0]   inv_tab [256];
    t_out_item    pending_blocks [$];
    int           n_mismatch;
    int           idle_cycles;
    bit           timed_out;
    bit           sink_run;

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input int m);
        logic [7:0] r;
        r = 8'h00;
        while (m != 0) begin
            if (m & 1) r ^= a;
            a = gf_dbl(a);
            m >>= 1;
        end
        return r;
    endfunction

    // inverse S-box, built from the forward one at start
    function automatic logic [7:0] sb_inv(input logic [7:0] y);
        return inv_tab[y];
    endfunction

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) sched[i] = cur_key[127 - 32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
                    ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic t_out_item cipher_block(input t_op op, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        int k [4];
        t_out_item res;
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
        for (int step = 0; step <= 10; step++) begin
            int rnd;
            rnd = (op == OP_ENC) ? step : 10 - step;
            if (step != 0) begin
                // row shift and byte substitution
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*c+r] = s[4*((op == OP_ENC) ? (c + r) % 4 : (c - r + 4) % 4) + r];
                for (int i = 0; i < 16; i++)
                    s[i] = (op == OP_ENC) ? sbox(t[i]) : sb_inv(t[i]);
                if (op == OP_ENC && step != 10) begin
                    k = '{2, 3, 1, 1};
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
                        for (int r = 0; r < 4; r++)
                            s[4*c+r] = gf_mul(a[r], k[0]) ^ gf_mul(a[(r+1)%4], k[1])
                                     ^ gf_mul(a[(r+2)%4], k[2]) ^ gf_mul(a[(r+3)%4], k[3]);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    s[4*c+r] ^= sched[4*rnd + c][31 - 8*r -: 8];
            // inverse mix comes after the key addition when decrypting
            if (op == OP_DEC && step != 0 && step != 10) begin
                k = '{14, 11, 13, 9};
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
                    for (int r = 0; r < 4; r++)
                        s[4*c+r] = gf_mul(a[r], k[0]) ^ gf_mul(a[(r+1)%4], k[1])
                                 ^ gf_mul(a[(r+2)%4], k[2]) ^ gf_mul(a[(r+3)%4], k[3]);
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.result_upper[63 - 8*i -: 8] = s[i];
            res.result_lower[63 - 8*i -: 8] = s[8+i];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // wait on idle-side edges; watchdog lives in its own block
    task automatic idle_wait(input int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_key_reg(input logic [0:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_KEY_UPPER) cur_key[127:64] = val;
        else cur_key[63:0] = val;
        expand_schedule();
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0) @(posedge clk);
        idle_wait(DRAIN_CYC);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        write_key_reg(REG_KEY_UPPER, hi);
        write_key_reg(REG_KEY_LOWER, lo);
        cfg_valid <= 1'b0;
    endtask

    // single transfer into the core; expectation queued on acceptance
    task automatic send_block(input t_op op, input logic [63:0] hi, input logic [63:0] lo,
                              input bit has_known, input t_out_item known);
        t_out_item exp_blk;
        in_valid <= 1'b1;
        in_data  <= '{req_type: op, block_upper: hi, block_lower: lo};
        do @(posedge clk); while (in_stall);
        exp_blk = cipher_block(op, {hi, lo});
        if (has_known && exp_blk != known)
            $display("predictor disagrees with known vector %h", known);
        pending_blocks.push_back(has_known ? known : exp_blk);
    endtask

    task automatic release_input(input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            idle_wait(gap);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_blocks.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", out_data);
            end else begin
                t_out_item want;
                want = pending_blocks.pop_front();
                if (out_data.result_upper != want.result_upper ||
                    out_data.result_lower != want.result_lower) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h_%h got %h_%h", want.result_upper,
                                 want.result_lower, out_data.result_upper,
                                 out_data.result_lower);
                end
            end
        end
    end

    // output backpressure
    initial begin
        int g;
        out_stall = 1'b0;
        wait (sink_run);
        forever begin
            g = pick_gap();
            if ($urandom_range(0, 9) < 2) g = 0;
            out_stall <= (g != 0);
            idle_wait(g == 0 ? $urandom_range(1, 20) : g);
        end
    end

    // watchdog on transfers of any kind
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            timed_out = 1'b1;
        end
    end

    t_vec vecs [$];

    initial begin
        t_vec v;
        t_out_item none;
        for (int b = 0; b < 256; b++) inv_tab[sbox(8'(b))] = 8'(b);
        none      = '0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_UPPER;
        cfg_data  = '0;
        sink_run  = 1'b0;
        n_mismatch = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        cur_key = '0;
        expand_schedule();

        // zero key straight after reset, extremes of the blocks
        vecs.push_back('{0, 0, 0, OP_ENC, 64'h0, 64'h0, 1,
                         '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1,
                         '{64'h0, 64'h0}});
        vecs.push_back('{0, 0, 0, OP_ENC, '1, '1, 0, none});
        vecs.push_back('{0, 0, 0, OP_DEC, '1, '1, 0, none});
        // FIPS-197 appendix C.1 vector
        vecs.push_back('{1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENC,
                         64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                         '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                         '{64'h0011223344556677, 64'h8899aabbccddeeff}});
        // appendix B vector
        vecs.push_back('{1, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, OP_ENC,
                         64'h3243f6a8885a308d, 64'h313198a2e0370734, 1,
                         '{64'h3925841d02dc09fb, 64'hdc118597196a0b32}});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1,
                         '{64'h3243f6a8885a308d, 64'h313198a2e0370734}});
        // all-ones key with extreme blocks, then alternating-bit and half-ones keys
        vecs.push_back('{1, '1, '1, OP_ENC, 64'h0, 64'h0, 0, none});
        vecs.push_back('{0, 0, 0, OP_ENC, '1, '1, 0, none});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h0, 64'h0, 0, none});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h8000000000000001, 64'h0123456789abcdef, 0, none});
        vecs.push_back('{1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, OP_ENC,
                         64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, none});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, none});
        vecs.push_back('{1, 64'h0, '1, OP_ENC, '1, 64'h0, 0, none});
        vecs.push_back('{0, 0, 0, OP_DEC, 64'h0, '1, 0, none});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        sink_run = 1'b1;

        foreach (vecs[i]) begin
            v = vecs[i];
            if (v.load_key) begin
                in_valid <= 1'b0;
                load_key(v.key_hi, v.key_lo);
            end
            send_block(v.op, v.blk_hi, v.blk_lo, v.has_known, v.known);
            release_input(pick_gap());
        end

        // random traffic in phases, each with its own key
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 240 == 0) begin
                in_valid <= 1'b0;
                // the drain inside load_key doubles as the full-pause hold-off
                load_key(rand64(), rand64());
            end
            send_block(t_op'($urandom_range(0, 1)), rand64(), rand64(), 0, none);
            release_input((n % 300 < 40) ? 0 : pick_gap());
        end
        in_valid <= 1'b0;
        drain();

        if (n_mismatch == 0 && pending_blocks.size() == 0 && !timed_out)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // timeout ends the run from its own process
    initial begin
        wait (timed_out);
        $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
rtl/aes128_pkg.sv
rtl/aes128_keymem.sv
rtl/aes128_block_cipher_core.sv
tb/testbench.sv
